[rtl/five_tuple_flow_hash_top_defines.svh]
// ---------------------------------------------------------------------------
// Five-tuple flow hash: assertion macros
// Clocked on clk_i; the plain form is disabled while rst_ni is low, the
// reset form is also checked during reset.
// ---------------------------------------------------------------------------
`ifndef FIVE_TUPLE_FLOW_HASH_TOP_DEFINES_SVH
`define FIVE_TUPLE_FLOW_HASH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FTH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FTH_ASSERT(lbl, prop, msg)
`define FTH_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/fth_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Five-tuple flow hash package
// Hash state type, initial value and the mix / final round slices.
// ---------------------------------------------------------------------------
package fth_pkg;

  localparam logic [31:0] HashInit = 32'hDEADBEEF;
  localparam logic [31:0] KeyBytes = 32'd13;
  localparam logic [31:0] InitBase = HashInit + KeyBytes;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hash_state_t;

  typedef struct packed {
    hash_state_t st;
    logic [7:0]  proto;
  } mix_item_t;

  // Rotate left by a constant amount (1..31)
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
    logic [5:0] r;
    r = 6'd32 - {1'b0, k};
    return (x << k) | (x >> r);
  endfunction

  // Mix round, first two lines
  function automatic hash_state_t mix_step1(input hash_state_t s);
    hash_state_t t;
    t = s;
    t.a = (t.a - t.c) ^ rotl(t.c, 5'd4);
    t.c = t.c + t.b;
    t.b = (t.b - t.a) ^ rotl(t.a, 5'd6);
    t.a = t.a + t.c;
    return t;
  endfunction

  // Mix round, middle two lines
  function automatic hash_state_t mix_step2(input hash_state_t s);
    hash_state_t t;
    t = s;
    t.c = (t.c - t.b) ^ rotl(t.b, 5'd8);
    t.b = t.b + t.a;
    t.a = (t.a - t.c) ^ rotl(t.c, 5'd16);
    t.c = t.c + t.b;
    return t;
  endfunction

  // Mix round, last two lines
  function automatic hash_state_t mix_step3(input hash_state_t s);
    hash_state_t t;
    t = s;
    t.b = (t.b - t.a) ^ rotl(t.a, 5'd19);
    t.a = t.a + t.c;
    t.c = (t.c - t.b) ^ rotl(t.b, 5'd4);
    t.b = t.b + t.a;
    return t;
  endfunction

  // Protocol byte add and final round, first two lines
  function automatic hash_state_t final_step1(input hash_state_t s,
                                              input logic [7:0] proto);
    hash_state_t t;
    t = s;
    t.a = t.a + {24'd0, proto};
    t.c = (t.c ^ t.b) - rotl(t.b, 5'd14);
    t.a = (t.a ^ t.c) - rotl(t.c, 5'd11);
    return t;
  endfunction

  // Final round, lines three and four
  function automatic hash_state_t final_step2(input hash_state_t s);
    hash_state_t t;
    t = s;
    t.b = (t.b ^ t.a) - rotl(t.a, 5'd25);
    t.c = (t.c ^ t.b) - rotl(t.b, 5'd16);
    return t;
  endfunction

  // Final round, lines five to seven
  function automatic hash_state_t final_step3(input hash_state_t s);
    hash_state_t t;
    t = s;
    t.a = (t.a ^ t.c) - rotl(t.c, 5'd4);
    t.b = (t.b ^ t.a) - rotl(t.a, 5'd14);
    t.c = (t.c ^ t.b) - rotl(t.b, 5'd24);
    return t;
  endfunction

endpackage

[rtl/fth_mix_pipe.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mix round pipeline
// Three register stages, two mix lines each; the protocol byte rides along.
// ---------------------------------------------------------------------------
module fth_mix_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fth_pkg::mix_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fth_pkg::mix_item_t out_data_o
);

  logic               valid_q [3];
  fth_pkg::mix_item_t data_q  [3];
  logic               adv     [3];

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    adv[2] = !valid_q[2] || !out_stall_i;
    adv[1] = !valid_q[1] || adv[2];
    adv[0] = !valid_q[0] || adv[1];
  end

  assign in_stall_o = !adv[0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
      valid_q[2] <= 1'b0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Hash state, two mix lines per stage
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      data_q[0].st    <= fth_pkg::mix_step1(in_data_i.st);
      data_q[0].proto <= in_data_i.proto;
    end
    if (adv[1]) begin
      data_q[1].st    <= fth_pkg::mix_step2(data_q[0].st);
      data_q[1].proto <= data_q[0].proto;
    end
    if (adv[2]) begin
      data_q[2].st    <= fth_pkg::mix_step3(data_q[1].st);
      data_q[2].proto <= data_q[1].proto;
    end
  end

  assign out_valid_o = valid_q[2];
  assign out_data_o  = data_q[2];

endmodule

[rtl/fth_final_pipe.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Final round pipeline
// Adds the protocol byte, then runs the final round over three stages.
// ---------------------------------------------------------------------------
module fth_final_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fth_pkg::mix_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        hash_o
);

  logic                 valid_q [3];
  fth_pkg::hash_state_t data_q  [3];
  logic                 adv     [3];

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    adv[2] = !valid_q[2] || !out_stall_i;
    adv[1] = !valid_q[1] || adv[2];
    adv[0] = !valid_q[0] || adv[1];
  end

  assign in_stall_o = !adv[0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
      valid_q[2] <= 1'b0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Hash state through the final round
  always_ff @(posedge clk_i) begin
    if (adv[0]) data_q[0] <= fth_pkg::final_step1(in_data_i.st, in_data_i.proto);
    if (adv[1]) data_q[1] <= fth_pkg::final_step2(data_q[0]);
    if (adv[2]) data_q[2] <= fth_pkg::final_step3(data_q[1]);
  end

  assign out_valid_o = valid_q[2];
  assign hash_o      = data_q[2].c;

endmodule

[rtl/five_tuple_flow_hash_top.sv]
`timescale 1ns / 1ps
// Throughput: one 5-tuple per cycle while out_stall_i is low, set by the seven-stage
// register pipeline (key add, three mix stages, three final-round stages).
// Reset clears all stage valid bits and sets the seed to 0; the pipeline
// accepts items from the first cycle after reset.
// ---------------------------------------------------------------------------
// Five-tuple flow hash top level
// Seeded 32-bit hash over the 13-byte flow key, fully pipelined.
// ---------------------------------------------------------------------------
`include "five_tuple_flow_hash_top_defines.svh"

module five_tuple_flow_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] destination_port_i,
  input  logic [7:0]  protocol_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] flow_hash_o
);

  logic [31:0]        init_q;
  logic               key_valid_q;
  fth_pkg::mix_item_t key_data_q;
  fth_pkg::mix_item_t key_data_d;
  logic               key_adv;
  logic               mix_stall;
  logic               mix_valid;
  fth_pkg::mix_item_t mix_data;
  logic               fin_stall;

  // Hold the initial state word, seed already folded in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= fth_pkg::InitBase;
    end else if (hash_seed_we_i) begin
      init_q <= fth_pkg::InitBase + hash_seed_i;
    end
  end

  // Add the three key words to the initial state
  always_comb begin
    key_data_d.st.a  = init_q + source_address_i;
    key_data_d.st.b  = init_q + destination_address_i;
    key_data_d.st.c  = init_q + {destination_port_i, source_port_i};
    key_data_d.proto = protocol_number_i;
  end

  assign key_adv    = !key_valid_q || !mix_stall;
  assign in_stall_o = !key_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q <= 1'b0;
    end else if (key_adv) begin
      key_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_adv) begin
      key_data_q <= key_data_d;
    end
  end

  fth_mix_pipe u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_valid_q),
    .in_stall_o  (mix_stall),
    .in_data_i   (key_data_q),
    .out_valid_o (mix_valid),
    .out_stall_i (fin_stall),
    .out_data_o  (mix_data)
  );

  fth_final_pipe u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_stall_o  (fin_stall),
    .in_data_i   (mix_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_o      (flow_hash_o)
  );

  // Reset leaves the output without a valid result
  `FTH_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid right after reset")
  // A seed write lands in the initial state word
  `FTH_ASSERT(a_seed_write, hash_seed_we_i |=> init_q == fth_pkg::InitBase + $past(hash_seed_i),
              "initial state does not follow seed write")
  // Input backpressure only when the output side is stalled
  `FTH_ASSERT(a_stall_source, in_stall_o |-> out_valid_o && out_stall_i,
              "input stalled while output side free")
  // A held key stage keeps its contents
  `FTH_ASSERT(a_key_hold, key_valid_q && mix_stall |=> key_valid_q && $stable(key_data_q),
              "key stage changed while stalled")

endmodule

[tb/tb_five_tuple_flow_hash_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Five-tuple flow hash testbench
// Sends a directed table of flow tuples followed by shaped random tuples
// under several hash seeds. Every transfer is predicted by a local model of
// the seeded 13-byte hash. Each output transfer is compared in order.
// ---------------------------------------------------------------------------

module tb_five_tuple_flow_hash_top;

  localparam logic [31:0] HashStart   = 32'hDEADBEEF;
  localparam logic [31:0] KeyLength   = 32'd13;
  // Seed that wraps the initial state to zero
  localparam logic [31:0] SeedZeroSum = 32'h21524104;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam int          NumDirected = 16;
  localparam int          NumPhases   = 5;
  localparam int          DrainCycles = 20;
  localparam int          CycleLimit  = 400000;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  proto;
  } flow_tuple_t;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        hash_seed_we_i        = 1'b0;
  logic [31:0] hash_seed_i           = '0;
  logic        in_valid_i            = 1'b0;
  logic        in_stall_o;
  logic [31:0] source_address_i      = '0;
  logic [31:0] destination_address_i = '0;
  logic [15:0] source_port_i         = '0;
  logic [15:0] destination_port_i    = '0;
  logic [7:0]  protocol_number_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i           = 1'b0;
  logic [31:0] flow_hash_o;

  logic [31:0] pending_hashes [$];
  logic [31:0] active_seed = '0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;

  // Directed tuples: extremes of each field, bit patterns, common flows
  flow_tuple_t directed_tuples [NumDirected] = '{
    '{32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF},
    '{32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00},
    '{32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 8'h00},
    '{32'h0000_0000, 32'h0000_0000, 16'hFFFF, 16'h0000, 8'h00},
    '{32'h0000_0000, 32'h0000_0000, 16'h0000, 16'hFFFF, 8'h00},
    '{32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 8'hFF},
    '{32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 8'hAA},
    '{32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 8'h55},
    '{32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80},
    '{32'h0000_0001, 32'h8000_0000, 16'h0001, 16'h8000, 8'h01},
    '{32'hC0A8_0001, 32'h0A00_0001, 16'd51000, 16'd443, ProtoTcp},
    '{32'h0A00_0001, 32'hC0A8_0001, 16'd443, 16'd51000, ProtoTcp},
    '{32'hAC10_0005, 32'h0808_0808, 16'd40000, 16'd53, ProtoUdp},
    '{32'h0A01_0203, 32'h0A01_0204, 16'h0000, 16'h0000, ProtoIcmp},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'h00}
  };

  five_tuple_flow_hash_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .hash_seed_we_i        (hash_seed_we_i),
    .hash_seed_i           (hash_seed_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .source_port_i         (source_port_i),
    .destination_port_i    (destination_port_i),
    .protocol_number_i     (protocol_number_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .flow_hash_o           (flow_hash_o)
  );

  // Free-running clock, 2 ns period
  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // Seeded hash of one tuple: key add, mix round, protocol add, final round
  function automatic logic [31:0] predict_flow_hash(input flow_tuple_t t,
                                                    input logic [31:0] seed);
    logic [31:0] a, b, c;
    a = HashStart + KeyLength + seed;
    b = a;
    c = a;
    a += t.src_addr;
    b += t.dst_addr;
    c += {t.l4_dport, t.l4_sport};
    a -= c; a ^= rot_left(c, 4);  c += b;
    b -= a; b ^= rot_left(a, 6);  a += c;
    c -= b; c ^= rot_left(b, 8);  b += a;
    a -= c; a ^= rot_left(c, 16); c += b;
    b -= a; b ^= rot_left(a, 19); a += c;
    c -= b; c ^= rot_left(b, 4);  b += a;
    a += {24'd0, t.proto};
    c ^= b; c -= rot_left(b, 14);
    a ^= c; a -= rot_left(c, 11);
    b ^= a; b -= rot_left(a, 25);
    c ^= b; c -= rot_left(b, 16);
    a ^= c; a -= rot_left(c, 4);
    b ^= a; b -= rot_left(a, 14);
    c ^= b; c -= rot_left(b, 24);
    return c;
  endfunction

  // Random tuple: mostly uniform, some sparse bit patterns and realistic flows
  function automatic flow_tuple_t random_tuple();
    flow_tuple_t t;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    t.src_addr = $urandom();
    t.dst_addr = $urandom();
    t.l4_sport = 16'($urandom_range(0, 16'hFFFF));
    t.l4_dport = 16'($urandom_range(0, 16'hFFFF));
    t.proto    = 8'($urandom_range(0, 8'hFF));
    case (kind)
      6: begin
        t.src_addr = 32'd1 << $urandom_range(0, 31);
        t.dst_addr = 32'd1 << $urandom_range(0, 31);
        t.l4_sport = 16'd1 << $urandom_range(0, 15);
        t.l4_dport = 16'd1 << $urandom_range(0, 15);
        t.proto    = 8'd1 << $urandom_range(0, 7);
      end
      7: begin
        t.src_addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        t.dst_addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        t.l4_sport = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        t.l4_dport = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        t.proto    = $urandom_range(0, 1) ? 8'hFF : 8'h0;
      end
      8, 9: begin
        t.src_addr = {8'd10, 24'($urandom())};
        t.dst_addr = {16'hC0A8, 16'($urandom())};
        t.l4_sport = 16'($urandom_range(1024, 16'hFFFF));
        t.l4_dport = 16'($urandom_range(1, 1023));
        t.proto    = $urandom_range(0, 1) ? ProtoTcp : ProtoUdp;
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  // Present one tuple, hold it until the transfer, record its hash
  task automatic send_tuple(input flow_tuple_t t);
    in_valid_i            <= 1'b1;
    source_address_i      <= t.src_addr;
    destination_address_i <= t.dst_addr;
    source_port_i         <= t.l4_sport;
    destination_port_i    <= t.l4_dport;
    protocol_number_i     <= t.proto;
    do @(posedge clk_i); while (in_stall_o);
    pending_hashes.push_back(predict_flow_hash(t, active_seed));
    // Close a burst with a random gap, then pick the next burst length
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 20);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every transfer has produced its hash
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_hash_seed(input logic [31:0] value);
    hash_seed_we_i <= 1'b1;
    hash_seed_i    <= value;
    @(posedge clk_i);
    hash_seed_we_i <= 1'b0;
    active_seed = value;
  endtask

  // Check output transfers in order and advance the stall pattern
  always @(posedge clk_i) begin
    int unsigned stall_mode;
    int          mode_left;
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_hashes.size() == 0) begin
          $error("unexpected flow_hash transfer: actual %08h", flow_hash_o);
          error_count++;
        end else begin
          want = pending_hashes.pop_front();
          if (flow_hash_o !== want) begin
            $error("flow_hash mismatch: expected %08h, actual %08h", want, flow_hash_o);
            error_count++;
          end
        end
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 4);
        mode_left  = $urandom_range(30, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        3:       out_stall_i <= ((mode_left % 3) == 0);
        default: out_stall_i <= ((mode_left % 16) < 10);
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then seeded random phases
  initial begin
    logic [31:0] phase_seeds [NumPhases];
    int          phase_items [NumPhases];
    phase_seeds = '{32'hFFFF_FFFF, SeedZeroSum, $urandom(), 32'h0000_0000, $urandom()};
    phase_items = '{100, 100, 150, 100, 150};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset seed, then again at the largest seed
    foreach (directed_tuples[i]) send_tuple(directed_tuples[i]);
    drain_pipeline();
    load_hash_seed(32'hFFFF_FFFF);
    foreach (directed_tuples[i]) send_tuple(directed_tuples[i]);

    for (int p = 0; p < NumPhases; p++) begin
      drain_pipeline();
      load_hash_seed(phase_seeds[p]);
      for (int n = 0; n < phase_items[p]; n++) send_tuple(random_tuple());
    end

    drain_pipeline();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_hashes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
